@@ design/pcov_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pcov_pkg;

   localparam int COORD_W    = 16;
   localparam int VERT_W     = 2 * COORD_W;
   localparam int HC_W       = COORD_W + 2;
   localparam int PROD_W     = 2 * HC_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int MAG_W      = SUM_W - 1;
   localparam int FRAC_SHIFT = 14;
   localparam int SQ_RAD_W   = PROD_W + FRAC_SHIFT;
   localparam int SQ_ROOT_W  = SQ_RAD_W / 2;
   localparam int SQ_REM_W   = SQ_ROOT_W + 2;
   localparam int MAG27_W    = 27;
   localparam int DIV_N_W    = 2 * MAG27_W;
   localparam int DIV_D_W    = PROD_W;
   localparam int DIV_Q_W    = 35;
   localparam int DIST_W     = 16;
   localparam int ALPHA_W    = 8;
   localparam int THICK_W    = 8;
   localparam int MODE_W     = 2;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [DIST_W-1:0]    DIST_MAX = '1;
   localparam logic [DIST_W-1:0]    HALF_PX  = DIST_W'(128);
   localparam logic [THICK_W-1:0]   THICK_RESET = THICK_W'(1);
   localparam logic [MODE_W-1:0]    MODE_RESET  = '0;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_THICKNESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd1;

   typedef struct packed {
      logic                 done;
      logic [SQ_ROOT_W-1:0] root;
   } sq_res_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quot;
   } div_res_type;

endpackage
`default_nettype wire

@@ design/polygon_coverage_alpha_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Antialiased coverage of a polyline or polygon held as a vertex list.
// A transaction is taken when start is high and busy is low. Opcode clear empties the
// list; append stores one vertex unless the list is full. A query walks the edges one
// at a time: the vertices sit in a ring of register stages that moves one place per
// edge, so the edge unit reads the first two stages (the closing edge pairs stage 0
// with a saved copy of vertex 0). An edge nearest an endpoint needs one 25-step square
// root; others need a root, a 27x27 multiply, a 35-step divide and a root, ending after
// the first root if it shows the distance saturates. After the last edge the ring keeps
// moving, one place a cycle, until it has turned MAX_VERTICES places in total; with
// fewer than two vertices the walk is skipped and the alpha is zero. The result shows
// on the rsp_ ports for one cycle with rsp_valid high; the receiver cannot stall it.
// Registers are written on the csr_ channel, which is always ready; the user must write
// them only while the block is idle, which the block leaves unenforced. Reset empties
// the vertex list, sets thickness to one and mode to open polyline; vertices stay.
module polygon_coverage_alpha_top #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [pcov_pkg::OP_W-1:0]             req_opcode,
   input  logic signed [pcov_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [pcov_pkg::COORD_W-1:0]   req_coord_y,
   output logic                                  rsp_valid,
   output logic signed [pcov_pkg::COORD_W-1:0]   rsp_pixel_x,
   output logic signed [pcov_pkg::COORD_W-1:0]   rsp_pixel_y,
   output logic [pcov_pkg::ALPHA_W-1:0]          rsp_coverage,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pcov_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pcov_pkg::THICK_W-1:0]          csr_data
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam logic [CNT_W-1:0] VMAX = CNT_W'(MAX_VERTICES);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LOAD = 4'd1;
   localparam logic [3:0] ST_MUL  = 4'd2;
   localparam logic [3:0] ST_SUM  = 4'd3;
   localparam logic [3:0] ST_SEL  = 4'd4;
   localparam logic [3:0] ST_SQL  = 4'd5;
   localparam logic [3:0] ST_SQM  = 4'd6;
   localparam logic [3:0] ST_DST  = 4'd7;
   localparam logic [3:0] ST_DIV  = 4'd8;
   localparam logic [3:0] ST_PT   = 4'd9;
   localparam logic [3:0] ST_UPD  = 4'd10;
   localparam logic [3:0] ST_ROT  = 4'd11;
   localparam logic [3:0] ST_OUT  = 4'd12;

   localparam int HC_W   = pcov_pkg::HC_W;
   localparam int PROD_W = pcov_pkg::PROD_W;
   localparam int SUM_W  = pcov_pkg::SUM_W;
   localparam int MAG_W  = pcov_pkg::MAG_W;
   localparam int DIST_W = pcov_pkg::DIST_W;
   localparam int LIM_W  = 28;

   function automatic logic [pcov_pkg::ALPHA_W-1:0] ramp_alpha(
      input logic [pcov_pkg::DIST_W-1:0] e);
      logic [7:0]  t;
      logic [15:0] prod;
      t    = 8'(pcov_pkg::HALF_PX - e);
      prod = {t, 8'b0} - 16'(t);
      ramp_alpha = (e >= pcov_pkg::HALF_PX) ? '0 : prod[15:8];
   endfunction

   function automatic logic [pcov_pkg::ALPHA_W-1:0] fill_alpha(
      input logic [pcov_pkg::DIST_W-1:0] e);
      logic [7:0]  t;
      logic [15:0] prod;
      t    = {1'b1, e[6:0]};
      prod = {t, 8'b0} - 16'(t);
      fill_alpha = (e >= pcov_pkg::HALF_PX) ? '1 : prod[15:8];
   endfunction

   logic [3:0]                         state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [CNT_W-1:0]                   rot_ff, rot_in;
   logic [pcov_pkg::THICK_W-1:0]       thick_ff, thick_in;
   logic [pcov_pkg::MODE_W-1:0]        mode_ff, mode_in;
   logic                               inside_ff, inside_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic signed [pcov_pkg::COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [pcov_pkg::VERT_W-1:0]         v0_ff, v0_in;
   logic signed [HC_W-1:0]              wx_ff, wx_in, wy_ff, wy_in;
   logic signed [HC_W-1:0]              dx_ff, dx_in, dy_ff, dy_in;
   logic signed [HC_W-1:0]              ux_ff, ux_in, uy_ff, uy_in;
   logic signed [PROD_W-1:0]            p_wxwx_ff, p_wywy_ff, p_dxdx_ff, p_dydy_ff;
   logic signed [PROD_W-1:0]            p_wxdx_ff, p_wydy_ff, p_wxdy_ff, p_wydx_ff;
   logic signed [PROD_W-1:0]            p_uxux_ff, p_uyuy_ff;
   logic [PROD_W-1:0]                   len2_ff, len2_in, e2a_ff, e2a_in, e2b_ff, e2b_in;
   logic signed [SUM_W-1:0]             dot_ff, dot_in, cr_ff, cr_in;
   logic [DIST_W-1:0]                   best_ff, best_in, d_ff, d_in;
   logic [pcov_pkg::MAG27_W-1:0]        mag27_ff, mag27_in;
   logic [pcov_pkg::DIV_N_W-1:0]        c2_ff, c2_in;
   logic signed [pcov_pkg::COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [pcov_pkg::ALPHA_W-1:0]        rsp_cov_ff, rsp_cov_in;

   logic [pcov_pkg::VERT_W-1:0] vert_q [MAX_VERTICES];
   logic [pcov_pkg::VERT_W-1:0] a_vert, b_vert;
   logic signed [HC_W-1:0]      cx_s, cy_s, ax_s, ay_s, bx_s, by_s;
   logic                        append_go, shift_go, sq_start, div_start;
   logic [pcov_pkg::SQ_RAD_W-1:0] sq_arg;
   pcov_pkg::sq_res_type        sq_res;
   pcov_pkg::div_res_type       div_res;
   logic                        closed, filled, last_edge;
   logic [CNT_W-1:0]            steps, rot_nx;
   logic [MAG_W-1:0]            mag;
   logic [LIM_W-1:0]            limit;
   logic [DIST_W-1:0]           half, err;
   logic [pcov_pkg::ALPHA_W-1:0] alpha;
   logic                        crossing, hit;

   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_chain
      pcov_cell u_cell (
         .clock     (clock),
         .load_en   (append_go && (count_ff == CNT_W'(k))),
         .load_data ({req_coord_y, req_coord_x}),
         .shift_en  (shift_go),
         .shift_in  (vert_q[(k + 1) % MAX_VERTICES]),
         .vert_out  (vert_q[k])
      );
   end

   pcov_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_arg),
      .res      (sq_res)
   );

   pcov_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (c2_ff),
      .denom (len2_ff),
      .res   (div_res)
   );

   assign closed    = (mode_ff != '0);
   assign filled    = mode_ff[1];
   assign steps     = closed ? count_ff : count_ff - CNT_W'(1);
   assign rot_nx    = rot_ff + CNT_W'(1);
   assign last_edge = (rot_ff == count_ff - CNT_W'(1));

   assign a_vert = vert_q[0];
   assign b_vert = last_edge ? v0_ff : vert_q[1];
   assign cx_s = HC_W'($signed({px_ff, 1'b1}));
   assign cy_s = HC_W'($signed({py_ff, 1'b1}));
   assign ax_s = HC_W'($signed({a_vert[pcov_pkg::COORD_W-1:0], 1'b0}));
   assign ay_s = HC_W'($signed({a_vert[pcov_pkg::VERT_W-1:pcov_pkg::COORD_W], 1'b0}));
   assign bx_s = HC_W'($signed({b_vert[pcov_pkg::COORD_W-1:0], 1'b0}));
   assign by_s = HC_W'($signed({b_vert[pcov_pkg::VERT_W-1:pcov_pkg::COORD_W], 1'b0}));

   assign len2_in = PROD_W'(p_dxdx_ff + p_dydy_ff);
   assign e2a_in  = PROD_W'(p_wxwx_ff + p_wywy_ff);
   assign e2b_in  = PROD_W'(p_uxux_ff + p_uyuy_ff);
   assign dot_in  = SUM_W'(p_wxdx_ff) + SUM_W'(p_wydy_ff);
   assign cr_in   = SUM_W'(p_wxdy_ff) - SUM_W'(p_wydx_ff);

   assign mag   = cr_ff[SUM_W-1] ? MAG_W'(-cr_ff) : MAG_W'(cr_ff);
   assign limit = {19'(sq_res.root[17:0]) + 19'd1, 9'b0};

   assign crossing = (wy_ff[HC_W-1] != uy_ff[HC_W-1]);
   assign hit      = (dy_ff > 0) ? (cr_in < 0) : (cr_in > 0);

   assign half  = DIST_W'({thick_ff, 7'b0});
   assign err   = (best_ff >= half) ? best_ff - half : half - best_ff;
   assign alpha = filled ? (inside_ff ? fill_alpha(best_ff) : ramp_alpha(best_ff))
                         : ramp_alpha(err);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rot_in       = rot_ff;
      thick_in     = thick_ff;
      mode_in      = mode_ff;
      inside_in    = inside_ff;
      rsp_valid_in = 1'b0;
      px_in        = px_ff;
      py_in        = py_ff;
      v0_in        = v0_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ux_in        = ux_ff;
      uy_in        = uy_ff;
      best_in      = best_ff;
      d_in         = d_ff;
      mag27_in     = mag27_ff;
      c2_in        = c2_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_cov_in   = rsp_cov_ff;
      append_go    = 1'b0;
      shift_go     = 1'b0;
      sq_start     = 1'b0;
      sq_arg       = '0;
      div_start    = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pcov_pkg::CSR_THICKNESS: thick_in = csr_data;
            pcov_pkg::CSR_MODE:      mode_in  = csr_data[pcov_pkg::MODE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_opcode)
                  pcov_pkg::OP_CLEAR: count_in = '0;
                  pcov_pkg::OP_APPEND: begin
                     if (count_ff < VMAX) begin
                        append_go = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  pcov_pkg::OP_QUERY: begin
                     px_in     = req_coord_x;
                     py_in     = req_coord_y;
                     rot_in    = '0;
                     best_in   = pcov_pkg::DIST_MAX;
                     inside_in = 1'b0;
                     v0_in     = vert_q[0];
                     state_in  = (count_ff < CNT_W'(2)) ? ST_OUT : ST_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD: begin
            wx_in    = cx_s - ax_s;
            wy_in    = cy_s - ay_s;
            dx_in    = bx_s - ax_s;
            dy_in    = by_s - ay_s;
            ux_in    = cx_s - bx_s;
            uy_in    = cy_s - by_s;
            state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_SUM;
         ST_SUM: begin
            inside_in = inside_ff ^ (crossing && hit);
            state_in  = ST_SEL;
         end
         ST_SEL: begin
            sq_start = 1'b1;
            priority if (len2_ff == '0 || dot_ff[SUM_W-1] || dot_ff == '0) begin
               sq_arg   = {e2a_ff, {pcov_pkg::FRAC_SHIFT{1'b0}}};
               state_in = ST_PT;
            end else if (dot_ff >= $signed({2'b00, len2_ff})) begin
               sq_arg   = {e2b_ff, {pcov_pkg::FRAC_SHIFT{1'b0}}};
               state_in = ST_PT;
            end else begin
               sq_arg   = pcov_pkg::SQ_RAD_W'(len2_ff);
               state_in = ST_SQL;
            end
         end
         ST_SQL: begin
            if (sq_res.done) begin
               mag27_in = mag[pcov_pkg::MAG27_W-1:0];
               if (mag >= MAG_W'(limit)) begin
                  d_in     = pcov_pkg::DIST_MAX;
                  state_in = ST_UPD;
               end else begin
                  state_in = ST_SQM;
               end
            end
         end
         ST_SQM: begin
            c2_in    = mag27_ff * mag27_ff;
            state_in = ST_DST;
         end
         ST_DST: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_res.done) begin
               sq_start = 1'b1;
               sq_arg   = pcov_pkg::SQ_RAD_W'(div_res.quot);
               state_in = ST_PT;
            end
         end
         ST_PT: begin
            if (sq_res.done) begin
               d_in = (sq_res.root > pcov_pkg::SQ_ROOT_W'(pcov_pkg::DIST_MAX))
                      ? pcov_pkg::DIST_MAX : sq_res.root[DIST_W-1:0];
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (d_ff < best_ff) begin
               best_in = d_ff;
            end
            shift_go = 1'b1;
            rot_in   = rot_nx;
            state_in = (rot_nx < steps) ? ST_LOAD : ST_ROT;
         end
         ST_ROT: begin
            if (rot_ff == VMAX) begin
               state_in = ST_OUT;
            end else begin
               shift_go = 1'b1;
               rot_in   = rot_nx;
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_x_in     = px_ff;
            rsp_y_in     = py_ff;
            rsp_cov_in   = (count_ff < CNT_W'(2)) ? '0 : alpha;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rot_ff       <= '0;
         thick_ff     <= pcov_pkg::THICK_RESET;
         mode_ff      <= pcov_pkg::MODE_RESET;
         inside_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rot_ff       <= rot_in;
         thick_ff     <= thick_in;
         mode_ff      <= mode_in;
         inside_ff    <= inside_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff      <= px_in;
      py_ff      <= py_in;
      v0_ff      <= v0_in;
      wx_ff      <= wx_in;
      wy_ff      <= wy_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      ux_ff      <= ux_in;
      uy_ff      <= uy_in;
      p_wxwx_ff  <= wx_ff * wx_ff;
      p_wywy_ff  <= wy_ff * wy_ff;
      p_dxdx_ff  <= dx_ff * dx_ff;
      p_dydy_ff  <= dy_ff * dy_ff;
      p_wxdx_ff  <= wx_ff * dx_ff;
      p_wydy_ff  <= wy_ff * dy_ff;
      p_wxdy_ff  <= wx_ff * dy_ff;
      p_wydx_ff  <= wy_ff * dx_ff;
      p_uxux_ff  <= ux_ff * ux_ff;
      p_uyuy_ff  <= uy_ff * uy_ff;
      len2_ff    <= len2_in;
      e2a_ff     <= e2a_in;
      e2b_ff     <= e2b_in;
      dot_ff     <= dot_in;
      cr_ff      <= cr_in;
      best_ff    <= best_in;
      d_ff       <= d_in;
      mag27_ff   <= mag27_in;
      c2_ff      <= c2_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_cov_ff <= rsp_cov_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pixel_x  = rsp_x_ff;
   assign rsp_pixel_y  = rsp_y_ff;
   assign rsp_coverage = rsp_cov_ff;

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Result strobe lasted more than one cycle.");

   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result delivered while a transaction is still in progress.");

   a_count_max : assert property (@(posedge clock) disable iff (reset)
      count_ff <= VMAX)
      else $error("Vertex count exceeds the list depth.");

   a_rot_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> (rot_ff < VMAX))
      else $error("Edge walk ran past the vertex ring.");

   a_clear : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == pcov_pkg::OP_CLEAR) |=> (count_ff == '0))
      else $error("Clear transaction did not empty the vertex list.");

endmodule
`default_nettype wire

@@ design/pcov_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pcov_cell (
   input  logic                        clock,
   input  logic                        load_en,
   input  logic [pcov_pkg::VERT_W-1:0] load_data,
   input  logic                        shift_en,
   input  logic [pcov_pkg::VERT_W-1:0] shift_in,
   output logic [pcov_pkg::VERT_W-1:0] vert_out
);

   logic [pcov_pkg::VERT_W-1:0] vert_ff;
   logic [pcov_pkg::VERT_W-1:0] vert_in;

   always_comb begin
      vert_in = vert_ff;
      priority if (shift_en) begin
         vert_in = shift_in;
      end else if (load_en) begin
         vert_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      vert_ff <= vert_in;
   end

   assign vert_out = vert_ff;

endmodule
`default_nettype wire

@@ design/pcov_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pcov_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pcov_pkg::SQ_RAD_W-1:0] radicand,
   output pcov_pkg::sq_res_type          res
);

   localparam int CNT_W = $clog2(pcov_pkg::SQ_ROOT_W);
   localparam int SH_W  = pcov_pkg::SQ_REM_W + 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(pcov_pkg::SQ_ROOT_W - 1);

   logic [pcov_pkg::SQ_RAD_W-1:0]  rad_ff, rad_in;
   logic [pcov_pkg::SQ_REM_W-1:0]  rem_ff, rem_in;
   logic [pcov_pkg::SQ_ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [SH_W-1:0]                rem_sh, trial, diff;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[pcov_pkg::SQ_REM_W-2:0], rad_ff[pcov_pkg::SQ_RAD_W-1 -: 2]};
      trial   = SH_W'({root_ff, 2'b01});
      diff    = rem_sh - trial;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (rem_sh >= trial) begin
            rem_in  = diff[pcov_pkg::SQ_REM_W-1:0];
            root_in = {root_ff[pcov_pkg::SQ_ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[pcov_pkg::SQ_REM_W-1:0];
            root_in = {root_ff[pcov_pkg::SQ_ROOT_W-2:0], 1'b0};
         end
         rad_in = rad_ff << 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign res.done = done_ff;
   assign res.root = root_ff;

endmodule
`default_nettype wire

@@ design/pcov_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pcov_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pcov_pkg::DIV_N_W-1:0] numer,
   input  logic [pcov_pkg::DIV_D_W-1:0] denom,
   output pcov_pkg::div_res_type        res
);

   localparam int CNT_W = $clog2(pcov_pkg::DIV_Q_W);
   localparam int WIDE_W = pcov_pkg::DIV_N_W + pcov_pkg::FRAC_SHIFT;
   localparam int SH_W = pcov_pkg::DIV_D_W + 1;
   localparam logic [CNT_W-1:0] LAST = CNT_W'(pcov_pkg::DIV_Q_W - 1);

   logic [WIDE_W-1:0]              wide;
   logic [pcov_pkg::DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [pcov_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [pcov_pkg::DIV_Q_W-1:0]   low_ff, low_in;
   logic [pcov_pkg::DIV_Q_W-1:0]   quot_ff, quot_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   logic [SH_W-1:0]                rem_sh, dvs_ext, diff;

   assign wide = {numer, {pcov_pkg::FRAC_SHIFT{1'b0}}};

   always_comb begin
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, low_ff[pcov_pkg::DIV_Q_W-1]};
      dvs_ext = {1'b0, dvs_ff};
      diff    = rem_sh - dvs_ext;
      if (start) begin
         dvs_in  = denom;
         rem_in  = pcov_pkg::DIV_D_W'(wide[WIDE_W-1:pcov_pkg::DIV_Q_W]);
         low_in  = wide[pcov_pkg::DIV_Q_W-1:0];
         quot_in = '0;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (rem_sh >= dvs_ext) begin
            rem_in  = diff[pcov_pkg::DIV_D_W-1:0];
            quot_in = {quot_ff[pcov_pkg::DIV_Q_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[pcov_pkg::DIV_D_W-1:0];
            quot_in = {quot_ff[pcov_pkg::DIV_Q_W-2:0], 1'b0};
         end
         low_in = low_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;

   localparam logic [pcov_pkg::OP_W-1:0]      OP_RESERVED = 2'd3;
   localparam logic [pcov_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [pcov_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [pcov_pkg::MODE_W-1:0]    MODE_OPEN   = 2'd0;
   localparam logic [pcov_pkg::MODE_W-1:0]    MODE_FILLED = 2'd2;
   localparam int NUM_VERTS = 64;
   localparam int NUM_ITEMS = 1500;

   typedef struct {
      logic signed [pcov_pkg::COORD_W-1:0] x;
      logic signed [pcov_pkg::COORD_W-1:0] y;
      logic [pcov_pkg::ALPHA_W-1:0]        cov;
   } pixel_alpha_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [pcov_pkg::OP_W-1:0] req_opcode = '0;
   logic signed [pcov_pkg::COORD_W-1:0] req_coord_x = '0;
   logic signed [pcov_pkg::COORD_W-1:0] req_coord_y = '0;
   logic rsp_valid;
   logic signed [pcov_pkg::COORD_W-1:0] rsp_pixel_x;
   logic signed [pcov_pkg::COORD_W-1:0] rsp_pixel_y;
   logic [pcov_pkg::ALPHA_W-1:0] rsp_coverage;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pcov_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pcov_pkg::THICK_W-1:0] csr_data = '0;

   pixel_alpha_type expected_alpha[$];
   logic [pcov_pkg::VERT_W-1:0] verts[NUM_VERTS];
   int unsigned nverts = 0;
   logic [pcov_pkg::THICK_W-1:0] thick_q = pcov_pkg::THICK_RESET;
   logic [pcov_pkg::MODE_W-1:0] mode_q = pcov_pkg::MODE_RESET;
   int errors = 0;
   int items = 0;
   bit idle_on = 1'b1;

   polygon_coverage_alpha_top #(.MAX_VERTICES(NUM_VERTS)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .rsp_valid(rsp_valid), .rsp_pixel_x(rsp_pixel_x), .rsp_pixel_y(rsp_pixel_y),
      .rsp_coverage(rsp_coverage), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned sat_dist(longint unsigned d);
      return (d > 65535) ? 65535 : d;
   endfunction

   function automatic longint unsigned point_gap(longint cx, longint cy, longint qx, longint qy);
      longint wx = cx - qx;
      longint wy = cy - qy;
      longint unsigned e2 = longint'(wx * wx) + longint'(wy * wy);
      return sat_dist(isqrt(e2 << 14));
   endfunction

   function automatic longint unsigned edge_gap(longint cx, longint cy, longint ax, longint ay,
                                                longint bx, longint by);
      longint dx = bx - ax;
      longint dy = by - ay;
      longint wx = cx - ax;
      longint wy = cy - ay;
      longint len2 = dx * dx + dy * dy;
      longint dot, c;
      longint unsigned mag, s, c2, q, r, v;
      if (len2 == 0) return point_gap(cx, cy, ax, ay);
      dot = wx * dx + wy * dy;
      if (dot <= 0) return point_gap(cx, cy, ax, ay);
      if (dot >= len2) return point_gap(cx, cy, bx, by);
      c = wx * dy - wy * dx;
      mag = (c < 0) ? -c : c;
      s = isqrt(len2);
      if (mag >= 512 * (s + 1)) return 65535;
      c2 = mag * mag;
      q = c2 / len2;
      r = c2 % len2;
      v = q * 16384 + (r * 16384) / len2;
      return sat_dist(isqrt(v));
   endfunction

   function automatic longint vx(int unsigned i);
      return 2 * longint'($signed(verts[i][15:0]));
   endfunction

   function automatic longint vy(int unsigned i);
      return 2 * longint'($signed(verts[i][31:16]));
   endfunction

   function automatic bit is_inside(longint cx, longint cy);
      bit in = 1'b0;
      int unsigned j = nverts - 1;
      longint ax, ay, bx, by, den, lhs, rhs;
      for (int unsigned i = 0; i < nverts; i++) begin
         ax = vx(i); ay = vy(i); bx = vx(j); by = vy(j);
         if ((ay > cy) != (by > cy)) begin
            den = by - ay;
            lhs = (cx - ax) * den;
            rhs = (bx - ax) * (cy - ay);
            if (den > 0 ? (lhs < rhs) : (lhs > rhs)) in = !in;
         end
         j = i;
      end
      return in;
   endfunction

   function automatic longint unsigned ramp(longint unsigned e);
      return (e >= 128) ? 0 : ((128 - e) * 255) / 256;
   endfunction

   function automatic logic [pcov_pkg::ALPHA_W-1:0] pixel_alpha(
      logic signed [pcov_pkg::COORD_W-1:0] px, logic signed [pcov_pkg::COORD_W-1:0] py);
      longint cx = 2 * longint'(px) + 1;
      longint cy = 2 * longint'(py) + 1;
      longint unsigned best = 65535;
      longint unsigned d, half, e;
      if (nverts < 2) return '0;
      for (int unsigned i = 0; i + 1 < nverts; i++) begin
         d = edge_gap(cx, cy, vx(i), vy(i), vx(i + 1), vy(i + 1));
         if (d < best) best = d;
      end
      if (mode_q != MODE_OPEN) begin
         d = edge_gap(cx, cy, vx(nverts - 1), vy(nverts - 1), vx(0), vy(0));
         if (d < best) best = d;
      end
      if (mode_q[1]) begin
         if (is_inside(cx, cy))
            return pcov_pkg::ALPHA_W'((best >= 128) ? 255 : ((best + 128) * 255) / 256);
         return pcov_pkg::ALPHA_W'(ramp(best));
      end
      half = longint'(thick_q) * 128;
      e = (best > half) ? best - half : half - best;
      return pcov_pkg::ALPHA_W'(ramp(e));
   endfunction

   task automatic gap(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_item(logic [pcov_pkg::OP_W-1:0] op,
                            logic signed [pcov_pkg::COORD_W-1:0] x,
                            logic signed [pcov_pkg::COORD_W-1:0] y);
      pixel_alpha_type p;
      if (idle_on && $urandom_range(0, 3) == 0) gap($urandom_range(1, 7));
      start <= 1'b1;
      req_opcode <= op;
      req_coord_x <= x;
      req_coord_y <= y;
      do @(posedge clock); while (busy);
      items++;
      case (op)
         pcov_pkg::OP_CLEAR: nverts = 0;
         pcov_pkg::OP_APPEND: begin
            if (nverts < NUM_VERTS) begin
               verts[nverts] = {y, x};
               nverts++;
            end
         end
         pcov_pkg::OP_QUERY: begin
            p.x = x; p.y = y; p.cov = pixel_alpha(x, y);
            expected_alpha.push_back(p);
         end
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_alpha.size() != 0 || busy) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic [pcov_pkg::CSR_IDX_W-1:0] idx,
                            logic [pcov_pkg::THICK_W-1:0] data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == pcov_pkg::CSR_THICKNESS) thick_q = data;
      else if (idx == pcov_pkg::CSR_MODE) mode_q = data[pcov_pkg::MODE_W-1:0];
   endtask

   function automatic logic signed [pcov_pkg::COORD_W-1:0] rand_coord();
      if ($urandom_range(0, 9) < 8)
         return pcov_pkg::COORD_W'($signed($urandom_range(0, 60)) - 30);
      return pcov_pkg::COORD_W'($urandom);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_alpha.size() == 0) begin
            errors++;
            if (errors <= 10) $display("Unexpected transaction: x=%0d y=%0d cov=%0d",
                                       rsp_pixel_x, rsp_pixel_y, rsp_coverage);
         end else begin
            pixel_alpha_type p;
            p = expected_alpha.pop_front();
            if (rsp_pixel_x !== p.x || rsp_pixel_y !== p.y || rsp_coverage !== p.cov) begin
               errors++;
               if (errors <= 10)
                  $display("Mismatch: expected x=%0d y=%0d cov=%0d, got x=%0d y=%0d cov=%0d",
                           p.x, p.y, p.cov, rsp_pixel_x, rsp_pixel_y, rsp_coverage);
            end
         end
      end
   end

   task automatic test_empty_list();
      send_item(pcov_pkg::OP_QUERY, 16'sd0, 16'sd0);
      send_item(pcov_pkg::OP_APPEND, 16'sd3, 16'sd3);
      send_item(pcov_pkg::OP_QUERY, 16'sd3, 16'sd3);
      send_item(OP_RESERVED, 16'sd5, 16'sd5);
      send_item(pcov_pkg::OP_APPEND, 16'sd10, 16'sd3);
      send_item(pcov_pkg::OP_QUERY, 16'sd6, 16'sd3);
      send_item(pcov_pkg::OP_QUERY, 16'sd6, 16'sd4);
   endtask

   task automatic test_extremes();
      send_item(pcov_pkg::OP_CLEAR, 16'sh7FFF, -16'sh8000);
      send_item(pcov_pkg::OP_APPEND, -16'sh8000, -16'sh8000);
      send_item(pcov_pkg::OP_APPEND, 16'sh7FFF, 16'sh7FFF);
      send_item(pcov_pkg::OP_APPEND, 16'sh7FFF, -16'sh8000);
      send_item(pcov_pkg::OP_QUERY, -16'sh8000, -16'sh8000);
      send_item(pcov_pkg::OP_QUERY, 16'sh7FFF, 16'sh7FFF);
      send_item(pcov_pkg::OP_QUERY, 16'sd0, 16'sd0);
      send_item(pcov_pkg::OP_QUERY, 16'sd0, -16'sd1);
   endtask

   task automatic test_modes();
      logic [pcov_pkg::MODE_W-1:0] m;
      for (int k = 0; k < 4; k++) begin
         m = pcov_pkg::MODE_W'(k);
         write_csr(pcov_pkg::CSR_MODE, {6'b101010, m});
         write_csr(pcov_pkg::CSR_THICKNESS, (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'd3);
         send_item(pcov_pkg::OP_CLEAR, 16'sd0, 16'sd0);
         send_item(pcov_pkg::OP_APPEND, 16'sd0, 16'sd0);
         send_item(pcov_pkg::OP_APPEND, 16'sd8, 16'sd0);
         send_item(pcov_pkg::OP_APPEND, 16'sd4, 16'sd8);
         send_item(pcov_pkg::OP_QUERY, 16'sd4, 16'sd3);
         send_item(pcov_pkg::OP_QUERY, 16'sd2, 16'sd4);
      end
      write_csr(CSR_SPARE_A, 8'hFF);
      write_csr(CSR_SPARE_B, 8'h00);
      send_item(pcov_pkg::OP_QUERY, 16'sd4, 16'sd0);
   endtask

   task automatic test_full_list();
      write_csr(pcov_pkg::CSR_MODE, MODE_FILLED);
      send_item(pcov_pkg::OP_CLEAR, 16'sd0, 16'sd0);
      for (int k = 0; k < NUM_VERTS + 2; k++)
         send_item(pcov_pkg::OP_APPEND, pcov_pkg::COORD_W'(k % 8) * 16'sd5,
                   pcov_pkg::COORD_W'(k / 8) * 16'sd5);
      send_item(pcov_pkg::OP_QUERY, 16'sd2, 16'sd2);
   endtask

   task automatic test_random();
      int shapes = 0;
      int k;
      logic signed [pcov_pkg::COORD_W-1:0] bx, by;
      while (items < NUM_ITEMS) begin
         if (items > NUM_ITEMS - 200) idle_on = 1'b0;
         shapes++;
         if (shapes % 15 == 0) begin
            case ($urandom_range(0, 3))
               0: write_csr(pcov_pkg::CSR_THICKNESS, 8'd255);
               1: write_csr(pcov_pkg::CSR_THICKNESS, 8'd1);
               default: write_csr(pcov_pkg::CSR_THICKNESS,
                                  pcov_pkg::THICK_W'($urandom_range(0, 12)));
            endcase
            write_csr(pcov_pkg::CSR_MODE, pcov_pkg::MODE_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) == 0)
               write_csr(pcov_pkg::CSR_IDX_W'(CSR_SPARE_A + $urandom_range(0, 1)),
                         pcov_pkg::THICK_W'($urandom));
         end
         if ($urandom_range(0, 9) < 9)
            send_item(pcov_pkg::OP_CLEAR, rand_coord(), rand_coord());
         k = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 6);
         bx = pcov_pkg::COORD_W'($signed($urandom_range(0, 40)) - 20);
         by = pcov_pkg::COORD_W'($signed($urandom_range(0, 40)) - 20);
         for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_item(pcov_pkg::OP_W'($urandom_range(0, 3)), rand_coord(), rand_coord());
            else if ($urandom_range(0, 19) == 0)
               send_item(pcov_pkg::OP_APPEND, rand_coord(), rand_coord());
            else
               send_item(pcov_pkg::OP_APPEND, bx + pcov_pkg::COORD_W'($urandom_range(0, 12)),
                         by + pcov_pkg::COORD_W'($urandom_range(0, 12)));
         end
         for (int i = $urandom_range(1, 6); i > 0; i--) begin
            if ($urandom_range(0, 9) == 0)
               send_item(pcov_pkg::OP_QUERY, rand_coord(), rand_coord());
            else
               send_item(pcov_pkg::OP_QUERY,
                         bx + pcov_pkg::COORD_W'($signed($urandom_range(0, 16)) - 2),
                         by + pcov_pkg::COORD_W'($signed($urandom_range(0, 16)) - 2));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_extremes();
      test_modes();
      test_full_list();
      test_random();
      wait_idle();
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
